// ===== rtl/ktrk_pkg.sv =====
// ----------------------------------------------------------------------------
// ktrk_pkg: shared types and constants for the k-th largest tracker
// Holds the store depth, counter widths, the link carried between cells and
// the helper that clamps the programmed rank into the legal range.
// ----------------------------------------------------------------------------
`default_nettype none

package ktrk_pkg;

    // Number of cells in the sorted chain (largest possible rank).
    localparam int MAX_RANK = 16;

    // Width of the rank register as seen on the configuration port.
    localparam int RANK_W = 5;
    // Width of a fill count, able to hold MAX_RANK itself.
    localparam int CNT_W = $clog2(MAX_RANK + 1);
    // Width of an index into the chain.
    localparam int IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    localparam int DATA_W = 32;

    // Value reported while fewer than k values are held.
    localparam logic signed [DATA_W-1:0] NOT_READY_VALUE = -32'sd1;

    // What one cell hands to the next one down the chain.
    typedef struct packed {
        logic signed [DATA_W-1:0] value; // held value of this cell
        logic                     ge;    // held and not smaller than the new item
    } t_link;

    // Rank zero counts as one, and anything above the depth saturates.
    function automatic logic [CNT_W-1:0] eff_rank(input logic [RANK_W-1:0] rank);
        int unsigned ru;
        ru = int'(rank);
        if (ru == 0) begin
            ru = 1;
        end
        if (ru > MAX_RANK) begin
            ru = MAX_RANK;
        end
        return CNT_W'(ru);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kth_largest_stream_tracker_top.sv =====
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker_top: running k-th largest value of a stream
// Each input item carries a signed 32-bit sample on i_s_tdata; i_s_tlast
// marks the final item of a sequence. For every item one result item leaves
// on the master side: o_m_tdata is the k-th largest value of the sequence so
// far and o_m_tuser is high once at least k values have been seen; before
// that o_m_tdata reads -1 with o_m_tuser low. After an item with tlast the
// store starts empty for the next sequence.
// The rank k is written through i_cfg_valid/i_cfg_data (always ready); the user
// is to write it only while idle, which the block does not enforce. Zero counts
// as one and values above 16 saturate. The values sit in a chain of 16 cells
// that all compare against the item in parallel and shift together, so one item
// is taken every clock unless the receiver stalls; its result is in the output
// register in the cycle after acceptance. While the receiver stalls, the result
// stays put and the slave side is held off, resuming in the cycle it is taken.
// Synchronous reset sets k to one, empties the store and drops o_m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_largest_stream_tracker_top
    import ktrk_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration: rank k
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [RANK_W-1:0]   i_cfg_data,
    // input items
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [DATA_W-1:0]   i_s_tdata,   // [31:0] value
    input  wire logic                i_s_tlast,   // last_item
    // result items
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [DATA_W-1:0]        o_m_tdata,   // [31:0] kth_value
    output logic                     o_m_tuser    // [0] ready_res
);

    logic [RANK_W-1:0]        r_rank;
    logic [CNT_W-1:0]         r_held;
    logic [CNT_W-1:0]         n_held;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_data;
    logic                     r_out_flag;

    logic                     w_acc;
    logic [CNT_W-1:0]         w_k;
    logic [CNT_W-1:0]         w_n;
    logic [CNT_W-1:0]         w_new_n;
    logic [IDX_W-1:0]         w_sel;
    logic signed [DATA_W-1:0] w_value;

    t_link                    w_link [MAX_RANK+1];
    logic signed [DATA_W-1:0] w_next [MAX_RANK];
    logic [MAX_RANK-1:0]      w_sorted_ok;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_value     = $signed(i_s_tdata);

    assign w_k     = eff_rank(r_rank);
    assign w_n     = (r_held < w_k) ? r_held : w_k;
    assign w_new_n = ((w_n + CNT_W'(1)) < w_k) ? (w_n + CNT_W'(1)) : w_k;
    assign w_sel   = IDX_W'(w_k - CNT_W'(1));

    // The slot above the first cell counts as not smaller than any item.
    assign w_link[0].value = '0;
    assign w_link[0].ge    = 1'b1;

    for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
        ktrk_cell u_cell (
            .i_clk        (i_clk),
            .i_en         (w_acc && (CNT_W'(g) < w_new_n)),
            .i_active     (CNT_W'(g) < w_n),
            .i_up         (w_link[g]),
            .i_value      (w_value),
            .o_link       (w_link[g+1]),
            .o_next_value (w_next[g])
        );
        if (g + 1 < MAX_RANK) begin : g_ord
            assign w_sorted_ok[g] = (CNT_W'(g + 1) >= w_n)
                || (w_link[g+1].value >= w_link[g+2].value);
        end else begin : g_ord_end
            assign w_sorted_ok[g] = 1'b1;
        end
    end

    always_comb begin
        n_held = r_held;
        if (w_acc) begin
            n_held = i_s_tlast ? '0 : w_new_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank      <= RANK_W'(1);
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_rank <= i_cfg_data;
            end
            r_held <= n_held;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (w_new_n == w_k) begin
                r_out_data <= w_next[w_sel];
                r_out_flag <= 1'b1;
            end else begin
                r_out_data <= NOT_READY_VALUE;
                r_out_flag <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_flag;

    // The fill count never passes the chain depth.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(MAX_RANK))
        else $error("fill count exceeds chain depth");

    // An item that ends a sequence leaves the store empty.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_tlast |=> r_held == '0)
        else $error("store not cleared after last item");

    // Held values stay sorted largest first.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_sorted_ok)
        else $error("held values out of order");

    // A result without the ready flag always carries minus one.
    a_not_ready_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == NOT_READY_VALUE)
        else $error("not-ready result carries a value");

    // The result of an accepted item shows up in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_m_tvalid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire

// ===== rtl/ktrk_cell.sv =====
// ----------------------------------------------------------------------------
// ktrk_cell: one slot of the sorted insertion chain
// Compares its held value with the new item and either keeps it, takes the
// new item, or takes the value of the neighbor above it.
// ----------------------------------------------------------------------------
`default_nettype none

module ktrk_cell
    import ktrk_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,     // item accepted and slot in range
    input  wire logic                     i_active, // slot currently holds a value
    input  wire t_link                    i_up,     // link from the neighbor above
    input  wire logic signed [DATA_W-1:0] i_value,  // new item
    output t_link                         o_link,
    output logic signed [DATA_W-1:0]      o_next_value
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     w_ge;

    assign w_ge = i_active && (r_value >= i_value);

    // The chain is sorted largest first, so the slot where the new item lands is
    // the first one not holding a value at least as large; its neighbor above does.
    always_comb begin
        n_value = r_value;
        if (i_en && !w_ge) begin
            if (i_up.ge) begin
                n_value = i_value;
            end else begin
                n_value = i_up.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.value = r_value;
    assign o_link.ge    = w_ge;
    assign o_next_value = n_value;

endmodule

`default_nettype wire
